/* design/hsc_pkg.sv */
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types and constants for the host name syntax checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned NameLimW  = 8;
  localparam int unsigned LabelLimW = 6;
  localparam int unsigned LabelCntW = 7;
  localparam int unsigned TotalCntW = 9;
  localparam int unsigned OutDataW  = 8;

  localparam logic [NameLimW-1:0]  NameLimRst  = 8'd253;
  localparam logic [LabelLimW-1:0] LabelLimRst = 6'd63;

  localparam logic [LabelCntW-1:0] LabelSat = 7'd127;
  localparam logic [TotalCntW-1:0] TotalSat = 9'd511;

  localparam logic [CharW-1:0] ChDot    = 8'h2e;
  localparam logic [CharW-1:0] ChHyphen = 8'h2d;

  // configuration register indexes
  localparam logic CfgMaxName  = 1'b0;
  localparam logic CfgMaxLabel = 1'b1;

  typedef struct packed {
    logic is_dot;
    logic is_hyphen;
    logic is_digit;
    logic is_letter;
  } char_class_t;

endpackage

`default_nettype wire

/* design/hsc_char_class.sv */
// ----------------------------------------------------------------------------
// hsc_char_class
// Sorts one byte into dot, hyphen, digit and letter classes.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_char_class (
  input  wire logic [hsc_pkg::CharW-1:0] char_code,
  output hsc_pkg::char_class_t           cls
);

  always_comb begin
    cls.is_dot    = (char_code == hsc_pkg::ChDot);
    cls.is_hyphen = (char_code == hsc_pkg::ChHyphen);
    cls.is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
    cls.is_letter = ((char_code >= 8'h61) && (char_code <= 8'h7a)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h5a));
  end

endmodule

`default_nettype wire

/* design/hsc_name_state.sv */
// ----------------------------------------------------------------------------
// hsc_name_state
// Per-name counters and flags, updated once per byte, and the verdict logic.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_name_state (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             step_en,
  input  wire hsc_pkg::char_class_t             cls,
  input  wire logic                             last_char,
  input  wire logic [hsc_pkg::NameLimW-1:0]     max_name_length,
  input  wire logic [hsc_pkg::LabelLimW-1:0]    max_label_length,
  output logic                                  name_valid
);

  logic [hsc_pkg::LabelCntW-1:0] label_count_r, label_count_nxt;
  logic [hsc_pkg::TotalCntW-1:0] total_count_r, total_count_nxt;
  logic                          prev_hyphen_r, prev_hyphen_nxt;
  logic                          all_digits_r,  all_digits_nxt;
  logic                          failed_r,      failed_nxt;

  logic [hsc_pkg::LabelCntW-1:0] label_lim;
  logic [hsc_pkg::TotalCntW-1:0] name_lim;

  assign label_lim = {1'b0, max_label_length};
  assign name_lim  = {1'b0, max_name_length};

  always_comb begin
    total_count_nxt = total_count_r;
    label_count_nxt = label_count_r;
    failed_nxt      = failed_r;
    all_digits_nxt  = all_digits_r;
    prev_hyphen_nxt = cls.is_hyphen;

    if (total_count_r != hsc_pkg::TotalSat) begin
      total_count_nxt = total_count_r + 1'b1;
    end

    if (cls.is_dot) begin
      // dot closes a label: must be non-empty, within limit, no trailing hyphen
      if ((label_count_r == '0) || (label_count_r > label_lim) || prev_hyphen_r) begin
        failed_nxt = 1'b1;
      end
      label_count_nxt = '0;
    end else begin
      if (!(cls.is_letter || cls.is_digit || cls.is_hyphen)) begin
        failed_nxt = 1'b1;
      end
      if ((label_count_r == '0) && cls.is_hyphen) begin
        failed_nxt = 1'b1;
      end
      if (!cls.is_digit) begin
        all_digits_nxt = 1'b0;
      end
      if (label_count_r != hsc_pkg::LabelSat) begin
        label_count_nxt = label_count_r + 1'b1;
      end
    end
  end

  assign name_valid = !failed_nxt &&
                      (total_count_nxt <= name_lim) &&
                      !cls.is_dot && !cls.is_hyphen &&
                      (label_count_nxt != '0) &&
                      (label_count_nxt <= label_lim) &&
                      !all_digits_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_count_r <= '0;
      total_count_r <= '0;
      prev_hyphen_r <= 1'b0;
      all_digits_r  <= 1'b1;
      failed_r      <= 1'b0;
    end else if (step_en) begin
      if (last_char) begin
        label_count_r <= '0;
        total_count_r <= '0;
        prev_hyphen_r <= 1'b0;
        all_digits_r  <= 1'b1;
        failed_r      <= 1'b0;
      end else begin
        label_count_r <= label_count_nxt;
        total_count_r <= total_count_nxt;
        prev_hyphen_r <= prev_hyphen_nxt;
        all_digits_r  <= all_digits_nxt;
        failed_r      <= failed_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* design/hostname_syntax_checker.sv */
// each byte is registered in the input register, and its verdict in the result register before out_tvalid
// throughput: one byte per cycle, a new byte accepted every cycle unless a last byte waits on a stalled verdict
// the result register decouples output stalls from the input register, but a last byte waits there for it
// reset (rst_n low, synchronous) empties both stages, clears name state and
// restores max_name_length = 253 and max_label_length = 63
// ----------------------------------------------------------------------------
// hostname_syntax_checker
// Streams a host name byte by byte and reports one verdict at the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hostname_syntax_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [hsc_pkg::CharW-1:0]       in_tdata,   // [7:0] char_code
  input  wire logic                            in_tlast,   // last_char
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [hsc_pkg::OutDataW-1:0]         out_tdata,  // [0] name_valid, [7:1] zero
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [hsc_pkg::NameLimW-1:0]    cfg_wdata
);

  logic [hsc_pkg::NameLimW-1:0]  max_name_r;
  logic [hsc_pkg::LabelLimW-1:0] max_label_r;

  logic                     s1_valid_r;
  logic [hsc_pkg::CharW-1:0] s1_char_r;
  logic                     s1_last_r;
  logic                     s1_adv;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_bit_r;

  hsc_pkg::char_class_t     cls;
  logic                     verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_name_r  <= hsc_pkg::NameLimRst;
      max_label_r <= hsc_pkg::LabelLimRst;
    end else if (cfg_we) begin
      case (cfg_index)
        hsc_pkg::CfgMaxName:  max_name_r  <= cfg_wdata;
        hsc_pkg::CfgMaxLabel: max_label_r <= cfg_wdata[hsc_pkg::LabelLimW-1:0];
        default: ;
      endcase
    end
  end

  // bytes without a verdict never wait on the output side
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  hsc_char_class u_class (
    .char_code (s1_char_r),
    .cls       (cls)
  );

  hsc_name_state u_state (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (s1_adv),
    .cls              (cls),
    .last_char        (s1_last_r),
    .max_name_length  (max_name_r),
    .max_label_length (max_label_r),
    .name_valid       (verdict)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_bit_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(hsc_pkg::OutDataW-1){1'b0}}, out_bit_r};

endmodule

`default_nettype wire

/* design/hsc_checker.sv */
// ----------------------------------------------------------------------------
// hsc_checker
// Port-level checks for the host name syntax checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [hsc_pkg::OutDataW-1:0]    out_tdata
);

  // a stalled verdict holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // only the verdict bit may be set
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("padding bits of out_tdata set");

  // an empty result register never blocks input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind hostname_syntax_checker hsc_checker u_hsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
